@@ hdl/ttc_pkg.sv @@
// ----------------------------------------------------------------------------
// ttc_pkg
// shared types, constants and reset values of the thermistor converter
// ----------------------------------------------------------------------------
package ttc_pkg;

  localparam int unsigned AdcW       = 12;
  localparam int unsigned SumW       = 20;
  localparam int unsigned CfgW       = 48;
  localparam int unsigned DvdW       = 68;
  localparam int unsigned DvsW       = 63;
  localparam int unsigned MulW       = 64;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;

  localparam int unsigned SamplesDef   = 16;
  localparam int unsigned AdcFullScale = 4095;
  localparam int unsigned CalSupplyMv  = 3300;

  localparam logic [11:0] VrefCodeRst    = 12'd1655;
  localparam logic [15:0] CalibOffsetRst = 16'd0;
  localparam logic [47:0] CoefARst       = 48'd348879179145;
  localparam logic [47:0] CoefBRst       = 48'd60620861986;
  localparam logic [47:0] CoefCRst       = 48'd47168775;

  typedef enum logic [2:0] {
    CFG_VREF_CODE    = 3'd0,
    CFG_CALIB_OFFSET = 3'd1,
    CFG_COEF_A       = 3'd2,
    CFG_COEF_B       = 3'd3,
    CFG_COEF_C       = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic            sample_ok;
    logic [AdcW-1:0] sense_sample;
    logic [AdcW-1:0] supply_sample;
    logic [AdcW-1:0] vref_sample;
    logic [AdcW-1:0] motor_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic signed [15:0] raw_tenths;
    logic [15:0]        motor_current_ma;
    logic               fault;
  } out_word_t;

  typedef struct packed {
    logic [SumW-1:0] sense;
    logic [SumW-1:0] supply;
    logic [SumW-1:0] vref;
    logic [SumW-1:0] motor;
  } sums_t;

  typedef struct packed {
    logic [11:0]        vref_code;
    logic signed [15:0] calib_offset;
    logic [47:0]        coef_a;
    logic [47:0]        coef_b;
    logic [47:0]        coef_c;
  } cfg_t;

  typedef struct packed {
    logic            start;
    logic [6:0]      steps;
    logic [DvdW-1:0] dividend;
    logic [DvsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [DvdW-1:0] quot;
  } div_rsp_t;

  typedef enum logic [4:0] {
    BK_IDLE,
    BK_AVG,
    BK_VP,
    BK_VS_MUL,
    BK_VS_DIV,
    BK_VC_MUL,
    BK_VC_DIV,
    BK_VM_MUL,
    BK_VM_DIV,
    BK_MV_DIV,
    BK_RATIO,
    BK_NORM,
    BK_SQR,
    BK_LN_MUL,
    BK_L2,
    BK_L3,
    BK_TB,
    BK_TC,
    BK_INV,
    BK_TDIV,
    BK_DONE
  } back_state_e;

endpackage

@@ hdl/ttc_div.sv @@
// ----------------------------------------------------------------------------
// ttc_div
// restoring divider, one quotient bit per cycle, dividend left aligned
// ----------------------------------------------------------------------------
module ttc_div import ttc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic            busy_q;
  logic [6:0]      cnt_q;
  logic [DvsW-1:0] rem_q;
  logic [DvsW-1:0] dvs_q;
  logic [DvdW-1:0] dvd_q;
  logic [DvdW-1:0] quot_q;
  logic [DvsW:0]   trial;
  logic [DvsW:0]   diff;
  logic            take;

  assign trial = {rem_q, dvd_q[DvdW-1]};
  assign take  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= req_i.steps;
    end else if (busy_q && cnt_q != 7'd0) begin
      cnt_q <= cnt_q - 7'd1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      dvd_q  <= req_i.dividend;
      dvs_q  <= req_i.divisor;
      quot_q <= '0;
    end else if (busy_q && cnt_q != 7'd0) begin
      rem_q  <= take ? diff[DvsW-1:0] : trial[DvsW-1:0];
      dvd_q  <= {dvd_q[DvdW-2:0], 1'b0};
      quot_q <= {quot_q[DvdW-2:0], take};
    end
  end

  assign rsp_o.done = busy_q && (cnt_q == 7'd0);
  assign rsp_o.quot = quot_q;

endmodule

@@ hdl/ttc_front.sv @@
// ----------------------------------------------------------------------------
// ttc_front
// accumulates sample words and hands a finished set of sums to the queue
// ----------------------------------------------------------------------------
module ttc_front import ttc_pkg::*; #(
  parameter int unsigned SAMPLES = SamplesDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_word_t in_word_i,
  input  logic     full_i,
  output logic     push_o,
  output sums_t    push_data_o
);

  localparam int unsigned CntW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

  logic [CntW-1:0] cnt_q;
  sums_t           sums_q;
  sums_t           sums_nxt;
  logic            last;
  logic            accept;

  assign last       = cnt_q == CntW'(SAMPLES - 1);
  assign in_stall_o = last && full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    sums_nxt = sums_q;
    if (in_word_i.sample_ok) begin
      sums_nxt.sense  = sums_q.sense + SumW'(in_word_i.sense_sample);
      sums_nxt.supply = sums_q.supply + SumW'(in_word_i.supply_sample);
      sums_nxt.vref   = sums_q.vref + SumW'(in_word_i.vref_sample);
      sums_nxt.motor  = sums_q.motor + SumW'(in_word_i.motor_sample);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sums_q <= '0;
    end else if (accept) begin
      if (last) begin
        cnt_q  <= '0;
        sums_q <= '0;
      end else begin
        cnt_q  <= cnt_q + CntW'(1);
        sums_q <= sums_nxt;
      end
    end
  end

  assign push_o      = accept && last;
  assign push_data_o = sums_nxt;

endmodule

@@ hdl/ttc_queue.sv @@
// ----------------------------------------------------------------------------
// ttc_queue
// two-entry queue of sum sets between front and back
// ----------------------------------------------------------------------------
module ttc_queue import ttc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  sums_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  vld_o,
  output sums_t data_o
);

  sums_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wptr_q;
  logic [QueuePtrW-1:0] rptr_q;
  logic [QueuePtrW:0]   cnt_q;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = cnt_q == (QueuePtrW+1)'(QueueDepth);
  assign vld_o   = cnt_q != '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && vld_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + QueuePtrW'(1);
      if (do_pop) rptr_q <= rptr_q + QueuePtrW'(1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (QueuePtrW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (QueuePtrW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_data_i;
  end

endmodule

@@ hdl/ttc_back.sv @@
// ----------------------------------------------------------------------------
// ttc_back
// sequencer that turns one set of sums into a temperature word
// ----------------------------------------------------------------------------
module ttc_back import ttc_pkg::*; #(
  parameter int unsigned SAMPLES = SamplesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_vld_i,
  input  sums_t     q_data_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam logic [1:0]  ChSense  = 2'd0;
  localparam logic [1:0]  ChSupply = 2'd1;
  localparam logic [1:0]  ChVref   = 2'd2;
  localparam logic [1:0]  ChMotor  = 2'd3;
  localparam logic [4:0]  SqrLast  = 5'd25;
  localparam logic [63:0] Ln2Q30   = 64'd744261118;
  localparam logic [56:0] RqBase   = 57'd65536000;
  localparam logic [59:0] TenQ56   = 60'd10 << 56;
  localparam logic signed [61:0] OffsetQ8 = 62'sd699264;
  localparam int unsigned UvPerMv  = 1000;

  // reciprocals scaled by 2^63, rounded up; exact floor for these operand widths
  localparam logic [63:0] RecipSamples =
    64'(((128'd1 << 63) + 128'(SAMPLES) - 128'd1) / 128'(SAMPLES));
  localparam logic [63:0] RecipFs =
    64'(((128'd1 << 63) + 128'(AdcFullScale) - 128'd1) / 128'(AdcFullScale));
  localparam logic [63:0] RecipMv =
    64'(((128'd1 << 63) + 128'(UvPerMv) - 128'd1) / 128'(UvPerMv));

  function automatic logic [60:0] cap_shr26(input logic [127:0] p);
    logic [101:0] s;
    s = p[127:26];
    return (s > {41'd0, 1'b1, 60'd0}) ? {1'b1, 60'd0} : s[60:0];
  endfunction

  function automatic logic [15:0] sat16(input logic signed [61:0] v);
    if (v > 62'sd32767) return 16'h7fff;
    if (v < -62'sd32768) return 16'h8000;
    return v[15:0];
  endfunction

  back_state_e st_q, st_d;
  logic        go_q, go_d;

  // sums and averages
  logic [3:0][SumW-1:0] sum_q;
  logic [3:0][AdcW-1:0] avg_q;
  logic [1:0]           idx_q;

  // supply path
  logic [34:0] vp_q;
  logic [46:0] prod_q;
  logic [39:0] vs_q;
  logic [38:0] vc_q;
  logic [38:0] vm_q;

  // log and polynomial
  logic [56:0] x_q;
  logic [5:0]  p_q;
  logic [30:0] m_q;
  logic [25:0] frac_q;
  logic [4:0]  it_q;
  logic [31:0] lm_q;
  logic        neg_q;
  logic [60:0] l2_q, l3_q, tb_q, tc_q;
  logic [62:0] inv_q;

  // result
  logic signed [15:0] temp_q, raw_q;
  logic [15:0]        ma_q;
  logic               fault_q;
  logic               out_vld_q;
  out_word_t          out_q;

  // shared units
  div_req_t     div_req;
  div_rsp_t     div_rsp;
  logic         mul_start;
  logic [63:0]  mul_a, mul_b;
  logic         mul_busy_q;
  logic [2:0]   mul_cnt_q;
  logic [63:0]  mul_a_q, mul_b_q;
  logic [127:0] mul_acc_q;
  logic [79:0]  mul_pp;
  logic         mul_done;
  logic         unit_done;
  logic         is_div, is_mul;

  // derived values
  logic [63:0]        cq;
  logic [34:0]        vp_num;
  logic [52:0]        num;
  logic [56:0]        ratio;
  logic               rq_pos;
  logic [31:0]        sq;
  logic signed [32:0] lg;
  logic [32:0]        lg_mag;
  logic [61:0]        term_sum;
  logic signed [63:0] inv;
  logic               inv_pos;
  logic signed [61:0] dq8;
  logic signed [61:0] tq;
  logic [15:0]        raw_new;
  logic [29:0]        mv;
  logic               out_free;

  ttc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // digit-serial multiplier, 16 bits of b per cycle, top digit first
  assign mul_pp   = {16'd0, mul_a_q} * {64'd0, mul_b_q[63:48]};
  assign mul_done = mul_busy_q && (mul_cnt_q == 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_busy_q <= 1'b0;
      mul_cnt_q  <= '0;
    end else if (mul_start) begin
      mul_busy_q <= 1'b1;
      mul_cnt_q  <= 3'd4;
    end else if (mul_busy_q && mul_cnt_q != 3'd0) begin
      mul_cnt_q <= mul_cnt_q - 3'd1;
    end else begin
      mul_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_start) begin
      mul_a_q   <= mul_a;
      mul_b_q   <= mul_b;
      mul_acc_q <= '0;
    end else if (mul_busy_q && mul_cnt_q != 3'd0) begin
      mul_acc_q <= {mul_acc_q[111:0], 16'd0} + {48'd0, mul_pp};
      mul_b_q   <= {mul_b_q[47:0], 16'd0};
    end
  end

  assign unit_done = div_rsp.done || mul_done;

  // quotient by a constant: product with its reciprocal, top bits
  assign cq = mul_acc_q[126:63];

  // combinational datapath
  assign vp_num   = 35'(CalSupplyMv * 1000) * {23'd0, cfg_i.vref_code};
  assign num      = 53'(vc_q - vs_q[38:0]) * 53'd10000;
  assign ratio    = (|div_rsp.quot[DvdW-1:56]) ? {1'b1, 56'd0} : div_rsp.quot[56:0];
  assign rq_pos   = ratio > RqBase;
  assign sq       = mul_acc_q[61:30];
  assign lg       = {7'({1'b0, p_q}) - 7'd16, frac_q};
  assign lg_mag   = lg[32] ? 33'(-lg) : 33'(lg);
  assign term_sum = {1'b0, tb_q} + {1'b0, tc_q};
  assign inv      = neg_q ? (64'(cfg_i.coef_a) - 64'(term_sum))
                          : (64'(cfg_i.coef_a) + 64'(term_sum));
  assign inv_pos  = !inv[63] && (inv != 64'sd0);
  assign dq8      = $signed({2'b00, div_rsp.quot[59:0]}) - OffsetQ8;
  assign tq       = dq8[61] ? -($signed(62'((-dq8) >> 8))) : (dq8 >>> 8);
  assign raw_new  = inv_pos ? sat16(tq) : 16'h7fff;
  assign mv       = cq[29:0];
  assign out_free = !out_vld_q || !out_stall_i;

  assign is_div = st_q inside {BK_VP, BK_RATIO, BK_TDIV};
  assign is_mul = st_q inside {BK_AVG, BK_VS_MUL, BK_VS_DIV, BK_VC_MUL, BK_VC_DIV,
                               BK_VM_MUL, BK_VM_DIV, BK_MV_DIV, BK_SQR, BK_LN_MUL,
                               BK_L2, BK_L3, BK_TB, BK_TC};

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      BK_IDLE:   if (q_vld_i) st_d = BK_AVG;
      BK_AVG: begin
        if (mul_done && idx_q == ChMotor) begin
          st_d = (avg_q[ChVref] == '0) ? BK_DONE : BK_VP;
        end
      end
      BK_VP:     if (div_rsp.done) st_d = BK_VS_MUL;
      BK_VS_MUL: if (mul_done) st_d = BK_VS_DIV;
      BK_VS_DIV: if (mul_done) st_d = BK_VC_MUL;
      BK_VC_MUL: if (mul_done) st_d = BK_VC_DIV;
      BK_VC_DIV: if (mul_done) st_d = BK_VM_MUL;
      BK_VM_MUL: if (mul_done) st_d = BK_VM_DIV;
      BK_VM_DIV: if (mul_done) st_d = BK_MV_DIV;
      BK_MV_DIV: begin
        if (mul_done) st_d = ({1'b0, vc_q} < vs_q) ? BK_DONE : BK_RATIO;
      end
      BK_RATIO:  if (div_rsp.done) st_d = rq_pos ? BK_NORM : BK_DONE;
      BK_NORM:   if (x_q[56]) st_d = BK_SQR;
      BK_SQR:    if (mul_done && it_q == SqrLast) st_d = BK_LN_MUL;
      BK_LN_MUL: if (mul_done) st_d = BK_L2;
      BK_L2:     if (mul_done) st_d = BK_L3;
      BK_L3:     if (mul_done) st_d = BK_TB;
      BK_TB:     if (mul_done) st_d = BK_TC;
      BK_TC:     if (mul_done) st_d = BK_INV;
      BK_INV:    st_d = inv_pos ? BK_TDIV : BK_DONE;
      BK_TDIV:   if (div_rsp.done) st_d = BK_DONE;
      BK_DONE:   if (out_free) st_d = BK_IDLE;
      default:   st_d = BK_IDLE;
    endcase
  end

  // unit requests
  always_comb begin
    div_req   = '0;
    mul_a     = '0;
    mul_b     = '0;
    q_pop_o   = 1'b0;
    case (st_q)
      BK_IDLE: q_pop_o = q_vld_i;
      BK_AVG: begin
        mul_a = 64'(sum_q[idx_q]);
        mul_b = RecipSamples;
      end
      BK_VP: begin
        div_req.dividend = {vp_num, 33'd0};
        div_req.steps    = 7'd35;
        div_req.divisor  = DvsW'(avg_q[ChVref]);
      end
      BK_VS_MUL: begin
        mul_a = 64'(vp_q);
        mul_b = 64'(avg_q[ChSense]);
      end
      BK_VC_MUL: begin
        mul_a = 64'(vp_q);
        mul_b = 64'(avg_q[ChSupply]);
      end
      BK_VM_MUL: begin
        mul_a = 64'(vp_q);
        mul_b = 64'(avg_q[ChMotor]);
      end
      BK_VS_DIV, BK_VC_DIV, BK_VM_DIV: begin
        mul_a = 64'(prod_q);
        mul_b = RecipFs;
      end
      BK_MV_DIV: begin
        mul_a = 64'(vm_q);
        mul_b = RecipMv;
      end
      BK_RATIO: begin
        div_req.dividend = {num[51:0], 16'd0};
        div_req.steps    = 7'd68;
        div_req.divisor  = DvsW'(vs_q);
      end
      BK_SQR: begin
        mul_a = 64'(m_q);
        mul_b = 64'(m_q);
      end
      BK_LN_MUL: begin
        mul_a = 64'(lg_mag);
        mul_b = Ln2Q30;
      end
      BK_L2: begin
        mul_a = 64'(lm_q);
        mul_b = 64'(lm_q);
      end
      BK_L3: begin
        mul_a = 64'(l2_q);
        mul_b = 64'(lm_q);
      end
      BK_TB: begin
        mul_a = 64'(cfg_i.coef_b);
        mul_b = 64'(lm_q);
      end
      BK_TC: begin
        mul_a = 64'(cfg_i.coef_c);
        mul_b = 64'(l3_q);
      end
      BK_TDIV: begin
        div_req.dividend = {TenQ56, 8'd0};
        div_req.steps    = 7'd60;
        div_req.divisor  = inv_q;
      end
      default: ;
    endcase
    div_req.start = is_div && !go_q;
    mul_start     = is_mul && !go_q;
    go_d          = go_q;
    if (div_req.start || mul_start) go_d = 1'b1;
    if (unit_done) go_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= BK_IDLE;
      go_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      go_q <= go_d;
      if (st_q == BK_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (st_q)
      BK_IDLE: begin
        sum_q   <= {q_data_i.motor, q_data_i.vref, q_data_i.supply, q_data_i.sense};
        idx_q   <= ChSense;
        temp_q  <= '0;
        raw_q   <= '0;
        ma_q    <= '0;
        fault_q <= 1'b0;
      end
      BK_AVG: begin
        if (mul_done) begin
          avg_q[idx_q] <= cq[AdcW-1:0];
          idx_q        <= idx_q + 2'd1;
          if (idx_q == ChMotor && cq[AdcW-1:0] == '0 && avg_q[ChVref] == '0) begin
            fault_q <= 1'b1;
          end else if (idx_q == ChMotor && avg_q[ChVref] == '0) begin
            fault_q <= 1'b1;
          end
        end
      end
      BK_VP:     if (div_rsp.done) vp_q <= div_rsp.quot[34:0];
      BK_VS_MUL, BK_VC_MUL, BK_VM_MUL: if (mul_done) prod_q <= mul_acc_q[46:0];
      BK_VS_DIV: if (mul_done) vs_q <= 40'(cq[38:0]) + 40'd1000;
      BK_VC_DIV: if (mul_done) vc_q <= cq[38:0];
      BK_VM_DIV: if (mul_done) vm_q <= cq[38:0];
      BK_MV_DIV: begin
        if (mul_done) begin
          ma_q <= (|mv[29:15]) ? 16'hffff : {mv[14:0], 1'b0};
          if ({1'b0, vc_q} < vs_q) fault_q <= 1'b1;
        end
      end
      BK_RATIO: begin
        if (div_rsp.done) begin
          x_q <= ratio - RqBase;
          p_q <= 6'd56;
          if (!rq_pos) fault_q <= 1'b1;
        end
      end
      BK_NORM: begin
        if (x_q[56]) begin
          m_q    <= x_q[56:26];
          frac_q <= '0;
          it_q   <= '0;
        end else begin
          x_q <= {x_q[55:0], 1'b0};
          p_q <= p_q - 6'd1;
        end
      end
      BK_SQR: begin
        if (mul_done) begin
          m_q    <= sq[31] ? sq[31:1] : sq[30:0];
          frac_q <= {frac_q[24:0], sq[31]};
          it_q   <= it_q + 5'd1;
        end
      end
      BK_LN_MUL: begin
        if (mul_done) begin
          lm_q  <= 32'((mul_acc_q[63:0] + 64'd536870912) >> 30);
          neg_q <= lg[32];
        end
      end
      BK_L2: if (mul_done) l2_q <= cap_shr26(mul_acc_q);
      BK_L3: if (mul_done) l3_q <= cap_shr26(mul_acc_q);
      BK_TB: if (mul_done) tb_q <= cap_shr26(mul_acc_q);
      BK_TC: if (mul_done) tc_q <= cap_shr26(mul_acc_q);
      BK_INV: begin
        inv_q <= inv[62:0];
        if (!inv_pos) begin
          raw_q  <= 16'sh7fff;
          temp_q <= sat16(62'sd32767 + 62'(cfg_i.calib_offset));
        end
      end
      BK_TDIV: begin
        if (div_rsp.done) begin
          raw_q  <= raw_new;
          temp_q <= sat16(62'($signed(raw_new)) + 62'(cfg_i.calib_offset));
        end
      end
      BK_DONE: begin
        if (out_free) begin
          out_q.temperature_tenths <= temp_q;
          out_q.raw_tenths         <= raw_q;
          out_q.motor_current_ma   <= ma_q;
          out_q.fault              <= fault_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

@@ hdl/thermistor_temperature_converter.sv @@
// ----------------------------------------------------------------------------
// thermistor_temperature_converter
// adc sample sets in, averaged per set, steinhart-hart temperature words out
// ----------------------------------------------------------------------------
// each input word is one adc sample set; sets with sample_ok are summed and
// every SAMPLES words the block emits one result word, the other words give
// none. the front takes one word per cycle and only stalls on the closing
// word of a set while two finished sets already wait in the queue. the back
// turns a set into a result, ending early when the reference is zero, and
// waits out any output stall. its time goes to the bit-serial divider (one
// quotient bit a cycle, three divisions by a variable divisor), the
// 16-bit-digit multiplier (the averages and the divisions by full scale and
// by 1000 are reciprocal products, and the log takes 26 squarings) and the
// normalizing shift ahead of the log. a finished result sits in the output
// register while the back may already wait for the next set.
// configuration: write enable, index (0 reference code, 1 calibration
// offset, 2..4 coefficients a, b, c) and data; write only while idle.
// ----------------------------------------------------------------------------
module thermistor_temperature_converter import ttc_pkg::*; #(
  parameter int unsigned SAMPLES = SamplesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_word_t        in_word_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_word_t       out_word_o,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  // configuration registers
  cfg_t  cfg_q;

  // front to queue
  logic  push;
  sums_t push_data;
  logic  q_full;

  // queue to back
  logic  q_vld;
  logic  q_pop;
  sums_t q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vref_code    <= VrefCodeRst;
      cfg_q.calib_offset <= CalibOffsetRst;
      cfg_q.coef_a       <= CoefARst;
      cfg_q.coef_b       <= CoefBRst;
      cfg_q.coef_c       <= CoefCRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_VREF_CODE:    cfg_q.vref_code    <= cfg_data_i[11:0];
        CFG_CALIB_OFFSET: cfg_q.calib_offset <= cfg_data_i[15:0];
        CFG_COEF_A:       cfg_q.coef_a       <= cfg_data_i[47:0];
        CFG_COEF_B:       cfg_q.coef_b       <= cfg_data_i[47:0];
        CFG_COEF_C:       cfg_q.coef_c       <= cfg_data_i[47:0];
        default: ; // unused index, write dropped
      endcase
    end
  end

  // accumulate and classify
  ttc_front #(
    .SAMPLES (SAMPLES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .full_i      (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // decouples front and back
  ttc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .vld_o       (q_vld),
    .data_o      (q_data)
  );

  // averaging, supply, resistance, log and polynomial
  ttc_back #(
    .SAMPLES (SAMPLES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_vld_i     (q_vld),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

@@ hdl/ttc_checker.sv @@
// ----------------------------------------------------------------------------
// ttc_checker
// port level checks of the thermistor converter, bound to the top level
// ----------------------------------------------------------------------------
module ttc_checker import ttc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  // a stalled word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  // a fault never carries a temperature
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.fault |->
      out_word_o.temperature_tenths == 16'sd0 && out_word_o.raw_tenths == 16'sd0)
    else $error("fault word with nonzero temperature");

  // current is twice a millivolt figure or saturated
  a_ma_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !out_word_o.motor_current_ma[0] ||
                    out_word_o.motor_current_ma == 16'hffff)
    else $error("odd motor current");

  // nothing leaves right out of reset
  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind thermistor_temperature_converter ttc_checker u_ttc_checker (.*);
